// ----- rtl/mrg_pkg.sv -----
package mrg_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_DONE
    } t_state;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_status;

    localparam t_mode MODE_ALLOC   = 2'd0;
    localparam t_mode MODE_ACCESS  = 2'd1;
    localparam t_mode MODE_RELEASE = 2'd2;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FAULT = 2'd1;
    localparam t_status STATUS_NOMEM = 2'd2;
    localparam t_status STATUS_FULL  = 2'd3;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    // accumulated result of one table scan
    typedef struct packed {
        logic conflict;
        logic hit;
        logic slot_found;
    } t_match;

endpackage

// ----- rtl/mrg_region_ram.sv -----
module mrg_region_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 81,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/mrg_match_unit.sv -----
module mrg_match_unit #(
    parameter int NUM_REGIONS = 16,
    parameter int ADDR_BITS   = 24,
    parameter int OWNER_BITS  = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_en,
    input  logic [$clog2(NUM_REGIONS)-1:0] i_idx,
    input  logic                           i_entry_vld,
    input  logic [OWNER_BITS-1:0]          i_e_owner,
    input  logic [ADDR_BITS-1:0]           i_e_base,
    input  logic [ADDR_BITS:0]             i_e_end,
    input  logic [OWNER_BITS-1:0]          i_q_owner,
    input  logic [ADDR_BITS-1:0]           i_q_base,
    input  logic [ADDR_BITS:0]             i_q_end,
    output logic                           o_owner_hit,
    output mrg_pkg::t_match                o_match,
    output logic [$clog2(NUM_REGIONS)-1:0] o_slot
);

    localparam int IDX_W = $clog2(NUM_REGIONS);
    localparam int END_W = ADDR_BITS + 1;

    logic [END_W-1:0] e_base_x;
    logic [END_W-1:0] q_base_x;
    logic             base_in;
    logic             end_in;
    logic             contained;
    logic             same_owner;

    mrg_pkg::t_match  r_match;
    mrg_pkg::t_match  n_match;
    logic [IDX_W-1:0] r_slot;
    logic [IDX_W-1:0] n_slot;

    assign e_base_x = {1'b0, i_e_base};
    assign q_base_x = {1'b0, i_q_base};

    always_comb begin
        base_in    = (q_base_x >= e_base_x) && (q_base_x < i_e_end);
        end_in     = (i_q_end >= e_base_x) && (i_q_end < i_e_end);
        contained  = (q_base_x >= e_base_x) && (i_q_end < i_e_end);
        same_owner = (i_e_owner == i_q_owner);

        n_match = r_match;
        n_slot  = r_slot;
        if (i_clear) begin
            n_match = '0;
        end else if (i_en) begin
            if (i_entry_vld) begin
                n_match.conflict = r_match.conflict | base_in | end_in;
                n_match.hit      = r_match.hit | (same_owner & contained);
            end else if (!r_match.slot_found) begin
                // lowest free slot wins
                n_match.slot_found = 1'b1;
                n_slot             = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= '0;
        end else begin
            r_match <= n_match;
        end
        r_slot <= n_slot;
    end

    assign o_owner_hit = i_en && i_entry_vld && same_owner;
    assign o_match     = r_match;
    assign o_slot      = r_slot;

endmodule

// ----- rtl/memory_region_guard_core.sv -----
// Region guard: keeps a table of NUM_REGIONS memory regions (owner, base, exclusive end,
// size) and a free memory count. Each request beat allocates a region, checks an access
// against the owner's regions, or releases all regions of an owner, and answers with one
// result beat (an unused mode gets a fault). How long a request takes is set by the single
// read port of the region table, which is scanned one region per cycle through one shared
// compare unit; the input is not ready until the result is loaded into the output register.
// A result waiting on the output does not stop the next request from being accepted. Writing
// total memory reloads the free count and leaves the table as it is; it is written only
// while no request is in flight.
module memory_region_guard_core #(
    parameter int NUM_REGIONS = 16,
    parameter int ADDR_BITS   = 24,
    parameter int OWNER_BITS  = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [ADDR_BITS-1:0]                 i_cfg_wr_data,   // total_memory
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // mode, owner_id, region_base, region_size
    input  logic [((2+OWNER_BITS+2*ADDR_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // status, free_left, regions_used
    output logic [((2+ADDR_BITS+$clog2(NUM_REGIONS+1)+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int IDX_W  = $clog2(NUM_REGIONS);
    localparam int CNT_W  = $clog2(NUM_REGIONS + 1);
    localparam int END_W  = ADDR_BITS + 1;
    localparam int EW     = OWNER_BITS + ADDR_BITS + END_W + ADDR_BITS;
    localparam int OUT_TW = ((2 + ADDR_BITS + CNT_W + 7) / 8) * 8;
    localparam int OFS_OWNER = mrg_pkg::MODE_W;
    localparam int OFS_BASE  = OFS_OWNER + OWNER_BITS;
    localparam int OFS_SIZE  = OFS_BASE + ADDR_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REGIONS - 1);
    localparam logic [END_W-1:0] SAT_MAX  = {1'b0, {ADDR_BITS{1'b1}}};

    mrg_pkg::t_state          r_state;
    mrg_pkg::t_state          n_state;
    mrg_pkg::t_mode           r_mode;
    logic [OWNER_BITS-1:0]    r_owner;
    logic [ADDR_BITS-1:0]     r_base;
    logic [ADDR_BITS-1:0]     r_size;
    logic [END_W-1:0]         r_end;
    logic [IDX_W-1:0]         r_rd_idx;
    logic [IDX_W-1:0]         n_rd_idx;
    logic                     r_issue;
    logic                     n_issue;
    logic                     r_pv;
    logic                     n_pv;
    logic [IDX_W-1:0]         r_pidx;
    logic [NUM_REGIONS-1:0]   r_valid;
    logic [NUM_REGIONS-1:0]   n_valid;
    logic [ADDR_BITS-1:0]     r_free;
    logic [ADDR_BITS-1:0]     n_free;
    logic [CNT_W-1:0]         r_used;
    logic [CNT_W-1:0]         n_used;
    mrg_pkg::t_status         r_status;
    mrg_pkg::t_status         n_status;
    logic                     r_out_vld;
    logic                     n_out_vld;
    logic [OUT_TW-1:0]        r_out_data;
    logic [OUT_TW-1:0]        n_out_data;

    logic                     accept;
    logic                     rd_en;
    logic                     wr_en;
    logic [EW-1:0]            wr_data;
    logic [EW-1:0]            rd_data;
    logic [OWNER_BITS-1:0]    e_owner;
    logic [ADDR_BITS-1:0]     e_base;
    logic [END_W-1:0]         e_end;
    logic [ADDR_BITS-1:0]     e_size;
    logic                     owner_hit;
    mrg_pkg::t_match          match;
    logic [IDX_W-1:0]         slot;
    logic [END_W-1:0]         rel_sum;

    assign o_s_axis_tready = (r_state == mrg_pkg::ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign {e_owner, e_base, e_end, e_size} = rd_data;
    assign wr_data = {r_owner, r_base, r_end, r_size};
    assign rd_en   = (r_state == mrg_pkg::ST_SCAN) && r_issue;
    assign rel_sum = {1'b0, r_free} + {1'b0, e_size};

    mrg_region_ram #(
        .DEPTH  (NUM_REGIONS),
        .WIDTH  (EW),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (slot),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    mrg_match_unit #(
        .NUM_REGIONS (NUM_REGIONS),
        .ADDR_BITS   (ADDR_BITS),
        .OWNER_BITS  (OWNER_BITS)
    ) u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (accept),
        .i_en        (r_pv),
        .i_idx       (r_pidx),
        .i_entry_vld (r_valid[r_pidx]),
        .i_e_owner   (e_owner),
        .i_e_base    (e_base),
        .i_e_end     (e_end),
        .i_q_owner   (r_owner),
        .i_q_base    (r_base),
        .i_q_end     (r_end),
        .o_owner_hit (owner_hit),
        .o_match     (match),
        .o_slot      (slot)
    );

    always_comb begin
        n_state    = r_state;
        n_rd_idx   = r_rd_idx;
        n_issue    = r_issue;
        n_pv       = 1'b0;
        n_valid    = r_valid;
        n_free     = r_free;
        n_used     = r_used;
        n_status   = r_status;
        n_out_vld  = r_out_vld;
        n_out_data = r_out_data;
        wr_en      = 1'b0;

        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            mrg_pkg::ST_IDLE: begin
                if (i_cfg_wr_en) begin
                    n_free = i_cfg_wr_data;
                end
                if (accept) begin
                    n_rd_idx = '0;
                    n_issue  = 1'b1;
                    n_state  = mrg_pkg::ST_SCAN;
                end
            end
            mrg_pkg::ST_SCAN: begin
                // each read is compared in the cycle after it is issued
                if (r_issue) begin
                    n_pv = 1'b1;
                    if (r_rd_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
                if (owner_hit && (r_mode == mrg_pkg::MODE_RELEASE)) begin
                    n_valid[r_pidx] = 1'b0;
                    n_free = (rel_sum > SAT_MAX) ? r_free | {ADDR_BITS{1'b1}}
                                                 : rel_sum[ADDR_BITS-1:0];
                    if (r_used != '0) begin
                        n_used = r_used - 1'b1;
                    end
                end
                if (r_pv && (r_pidx == LAST_IDX)) begin
                    n_state = mrg_pkg::ST_FINISH;
                end
            end
            mrg_pkg::ST_FINISH: begin
                unique case (r_mode)
                    mrg_pkg::MODE_ALLOC: begin
                        if (match.conflict) begin
                            n_status = mrg_pkg::STATUS_FAULT;
                        end else if (r_size > r_free) begin
                            n_status = mrg_pkg::STATUS_NOMEM;
                        end else if (!match.slot_found) begin
                            n_status = mrg_pkg::STATUS_FULL;
                        end else begin
                            n_status      = mrg_pkg::STATUS_OK;
                            wr_en         = 1'b1;
                            n_valid[slot] = 1'b1;
                            n_free        = r_free - r_size;
                            n_used        = r_used + 1'b1;
                        end
                    end
                    mrg_pkg::MODE_ACCESS: begin
                        n_status = match.hit ? mrg_pkg::STATUS_OK : mrg_pkg::STATUS_FAULT;
                    end
                    mrg_pkg::MODE_RELEASE: begin
                        n_status = mrg_pkg::STATUS_OK;
                    end
                    default: begin
                        n_status = mrg_pkg::STATUS_FAULT;
                    end
                endcase
                n_state = mrg_pkg::ST_DONE;
            end
            mrg_pkg::ST_DONE: begin
                // wait for the output register to drain
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = OUT_TW'({r_used, r_free, r_status});
                    n_state    = mrg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mrg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mrg_pkg::ST_IDLE;
            r_issue   <= 1'b0;
            r_pv      <= 1'b0;
            r_valid   <= '0;
            r_free    <= '0;
            r_used    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_pv      <= n_pv;
            r_valid   <= n_valid;
            r_free    <= n_free;
            r_used    <= n_used;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_s_axis_tdata[mrg_pkg::MODE_W-1:0];
            r_owner <= i_s_axis_tdata[OFS_OWNER +: OWNER_BITS];
            r_base  <= i_s_axis_tdata[OFS_BASE +: ADDR_BITS];
            r_size  <= i_s_axis_tdata[OFS_SIZE +: ADDR_BITS];
            r_end   <= {1'b0, i_s_axis_tdata[OFS_BASE +: ADDR_BITS]}
                     + {1'b0, i_s_axis_tdata[OFS_SIZE +: ADDR_BITS]};
        end
        r_rd_idx   <= n_rd_idx;
        r_pidx     <= r_rd_idx;
        r_status   <= n_status;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ----- bench/memory_region_guard_core_test.sv -----
module memory_region_guard_core_test;

    localparam int NUM_REGIONS = 16;
    localparam int ADDR_BITS   = 24;
    localparam int OWNER_BITS  = 8;
    localparam int IN_W        = ((2 + OWNER_BITS + 2 * ADDR_BITS + 7) / 8) * 8;
    localparam int OUT_W       = ((2 + ADDR_BITS + $clog2(NUM_REGIONS + 1) + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam mrg_pkg::t_mode MODE_UNUSED = 2'd3;
    localparam logic [ADDR_BITS-1:0] ADDR_MAX = {ADDR_BITS{1'b1}};

    typedef logic [OWNER_BITS-1:0] t_owner;
    typedef logic [ADDR_BITS-1:0]  t_addr;

    typedef struct packed {
        mrg_pkg::t_status status;
        t_addr            free_left;
        logic [4:0]       regions_used;
    } t_reply;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    t_addr            cfg_wr_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // region table mirror
    logic            region_valid [NUM_REGIONS];
    t_owner          region_owner [NUM_REGIONS];
    t_addr           region_base  [NUM_REGIONS];
    logic [ADDR_BITS:0] region_end [NUM_REGIONS];
    t_addr           region_size  [NUM_REGIONS];
    t_addr           free_count = '0;
    logic [4:0]      used_regions = '0;

    t_reply expected_replies [$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    bit     idling_on = 1'b1;

    memory_region_guard_core #(
        .NUM_REGIONS (NUM_REGIONS),
        .ADDR_BITS   (ADDR_BITS),
        .OWNER_BITS  (OWNER_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic bit in_region(int idx, logic [ADDR_BITS:0] addr);
        return addr >= {1'b0, region_base[idx]} && addr < region_end[idx];
    endfunction

    // updates the table mirror and returns the status of one request
    function automatic mrg_pkg::t_status guard_request(mrg_pkg::t_mode mode, t_owner owner,
                                                       t_addr base, t_addr size);
        logic [ADDR_BITS:0] req_end;
        logic [ADDR_BITS:0] sum;
        int slot;
        req_end = {1'b0, base} + {1'b0, size};
        slot = -1;
        case (mode)
            mrg_pkg::MODE_ALLOC: begin
                for (int i = 0; i < NUM_REGIONS; i++)
                    if (region_valid[i] &&
                        (in_region(i, {1'b0, base}) || in_region(i, req_end)))
                        return mrg_pkg::STATUS_FAULT;
                if (size > free_count)
                    return mrg_pkg::STATUS_NOMEM;
                for (int i = NUM_REGIONS - 1; i >= 0; i--)
                    if (!region_valid[i])
                        slot = i;
                if (slot < 0)
                    return mrg_pkg::STATUS_FULL;
                region_valid[slot] = 1'b1;
                region_owner[slot] = owner;
                region_base[slot]  = base;
                region_end[slot]   = req_end;
                region_size[slot]  = size;
                free_count   = free_count - size;
                used_regions = used_regions + 1'b1;
                return mrg_pkg::STATUS_OK;
            end
            mrg_pkg::MODE_ACCESS: begin
                for (int i = 0; i < NUM_REGIONS; i++)
                    if (region_valid[i] && region_owner[i] == owner &&
                        base >= region_base[i] && req_end < region_end[i])
                        return mrg_pkg::STATUS_OK;
                return mrg_pkg::STATUS_FAULT;
            end
            mrg_pkg::MODE_RELEASE: begin
                for (int i = 0; i < NUM_REGIONS; i++) begin
                    if (region_valid[i] && region_owner[i] == owner) begin
                        region_valid[i] = 1'b0;
                        sum = {1'b0, free_count} + {1'b0, region_size[i]};
                        free_count = sum[ADDR_BITS] ? ADDR_MAX : sum[ADDR_BITS-1:0];
                        if (used_regions > 0)
                            used_regions = used_regions - 1'b1;
                    end
                end
                return mrg_pkg::STATUS_OK;
            end
            default: return mrg_pkg::STATUS_FAULT;
        endcase
    endfunction

    task automatic send_request(mrg_pkg::t_mode mode, t_owner owner, t_addr base,
                                t_addr size);
        t_reply want;
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_tdata  <= IN_W'({size, base, owner, mode});
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        want.status       = guard_request(mode, owner, base, size);
        want.free_left    = free_count;
        want.regions_used = used_regions;
        expected_replies.push_back(want);
    endtask

    // sender holds off until every reply is back
    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_total_memory(t_addr total);
        wait_drained();
        @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= total;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        free_count = total;
    endtask

    // receiver stalls in bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (idling_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic note_mismatch(string what, t_reply want, t_reply got);
        if (mismatch_count < 10)
            $display("mismatch (%s): expected %0d/%0h/%0d, got %0d/%0h/%0d",
                     what, want.status, want.free_left, want.regions_used,
                     got.status, got.free_left, got.regions_used);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_replies
        t_reply got;
        t_reply want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.status       = m_tdata[1:0];
            got.free_left    = m_tdata[2 +: ADDR_BITS];
            got.regions_used = m_tdata[2 + ADDR_BITS +: 5];
            if (expected_replies.size() == 0) begin
                note_mismatch("unexpected beat", '0, got);
            end else begin
                want = expected_replies.pop_front();
                if (got.status != want.status)
                    note_mismatch("status", want, got);
                else if (got.free_left != want.free_left)
                    note_mismatch("free_left", want, got);
                else if (got.regions_used != want.regions_used)
                    note_mismatch("regions_used", want, got);
            end
        end
    end

    // reset budget of zero: only a zero-size region fits
    task automatic test_zero_budget();
        send_request(mrg_pkg::MODE_ALLOC, 8'h01, 24'h000100, 24'h0);
        send_request(mrg_pkg::MODE_ALLOC, 8'h01, 24'h000200, 24'h1);
    endtask

    task automatic test_field_extremes();
        load_total_memory(ADDR_MAX);
        send_request(mrg_pkg::MODE_ALLOC, 8'hFF, ADDR_MAX, ADDR_MAX);
        send_request(mrg_pkg::MODE_ACCESS, 8'hFF, ADDR_MAX, 24'h0);
        send_request(mrg_pkg::MODE_ACCESS, 8'hFF, ADDR_MAX, ADDR_MAX);   // end equal, strict
        send_request(mrg_pkg::MODE_ACCESS, 8'h00, ADDR_MAX, 24'h0);
        send_request(mrg_pkg::MODE_ALLOC, 8'h03, 24'h0, ADDR_MAX);       // end lands in region
        send_request(mrg_pkg::MODE_ALLOC, 8'h03, 24'h0, 24'h1);          // no memory left
        send_request(mrg_pkg::MODE_RELEASE, 8'hFF, 24'h0, 24'h0);
        send_request(mrg_pkg::MODE_RELEASE, 8'h55, ADDR_MAX, ADDR_MAX);  // owner holds nothing
        send_request(MODE_UNUSED, 8'hAA, 24'h123456, 24'hABCDEF);
    endtask

    task automatic test_overlap_rules();
        send_request(mrg_pkg::MODE_ALLOC, 8'h04, 24'h000010, 24'h000020);
        send_request(mrg_pkg::MODE_ALLOC, 8'h05, 24'h000020, 24'h000100);   // base inside
        send_request(mrg_pkg::MODE_ALLOC, 8'h05, 24'h000000, 24'h000010);   // end at base
        send_request(mrg_pkg::MODE_ALLOC, 8'h05, 24'h000030, 24'h000010);   // adjacent above
        send_request(mrg_pkg::MODE_ACCESS, 8'h04, 24'h000010, 24'h00001F);
        send_request(mrg_pkg::MODE_RELEASE, 8'h04, 24'h0, 24'h0);
        send_request(mrg_pkg::MODE_RELEASE, 8'h05, 24'h0, 24'h0);
        send_request(mrg_pkg::MODE_RELEASE, 8'h01, 24'h0, 24'h0);
    endtask

    task automatic test_table_full();
        load_total_memory(24'h010000);
        for (int i = 0; i < NUM_REGIONS; i++)
            send_request(mrg_pkg::MODE_ALLOC, 8'h10 + 8'(i % 2),
                         24'h100000 + 24'(i * 'h100), 24'h80);
        // overlap wins over full
        send_request(mrg_pkg::MODE_ALLOC, 8'h20, 24'h100040, 24'h10);
        // no memory wins over full
        send_request(mrg_pkg::MODE_ALLOC, 8'h20, 24'h200000, 24'h020000);
        send_request(mrg_pkg::MODE_ALLOC, 8'h20, 24'h200000, 24'h10);
    endtask

    // reloading the budget under a full table, then giving back, saturates
    task automatic test_release_saturation();
        load_total_memory(ADDR_MAX - 24'h100);
        send_request(mrg_pkg::MODE_RELEASE, 8'h10, 24'h0, 24'h0);
        send_request(mrg_pkg::MODE_RELEASE, 8'h11, 24'h0, 24'h0);
    endtask

    task automatic test_random_traffic(int count, t_addr total);
        t_owner owners [4];
        t_addr  window;
        t_addr  base;
        t_addr  size;
        mrg_pkg::t_mode mode;
        t_owner owner;
        int     pick;
        int     idx;
        int     off;
        load_total_memory(total);
        foreach (owners[i]) owners[i] = t_owner'($urandom);
        window = t_addr'($urandom_range(0, 32'hFF0000));
        for (int n = 0; n < count; n++) begin
            pick  = $urandom_range(0, 99);
            owner = owners[$urandom_range(0, 3)];
            if ($urandom_range(0, 9) == 0)
                owner = t_owner'($urandom);
            base = window + t_addr'($urandom_range(0, 47) * 1024)
                 + t_addr'($urandom_range(0, 200));
            size = ($urandom_range(0, 9) == 0) ? t_addr'($urandom_range(0, 8000))
                                               : t_addr'($urandom_range(0, 700));
            if (pick < 5) begin
                mode = mrg_pkg::t_mode'($urandom_range(0, 3));
                base = t_addr'($urandom);
                size = t_addr'($urandom);
            end else if (pick < 50) begin
                mode = mrg_pkg::MODE_ALLOC;
            end else if (pick < 80) begin
                mode = mrg_pkg::MODE_ACCESS;
                idx  = $urandom_range(0, NUM_REGIONS - 1);
                if (region_valid[idx] && $urandom_range(0, 4) != 0) begin
                    if ($urandom_range(0, 6) != 0)
                        owner = region_owner[idx];
                    off  = int'($urandom_range(0, int'(region_size[idx])));
                    base = region_base[idx] + t_addr'(off);
                    size = t_addr'($urandom_range(0, int'(region_size[idx]) - off + 1));
                end
            end else if (pick < 97) begin
                mode = mrg_pkg::MODE_RELEASE;
            end else begin
                mode = MODE_UNUSED;
            end
            send_request(mode, owner, base, size);
        end
    endtask

    initial begin
        foreach (region_valid[i]) region_valid[i] = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_budget();
        test_field_extremes();
        test_overlap_rules();
        test_table_full();
        test_release_saturation();

        test_random_traffic(200, 24'h0);
        test_random_traffic(200, 24'd20000);
        test_random_traffic(200, ADDR_MAX);
        test_random_traffic(200, 24'd5000);
        test_random_traffic(200, t_addr'($urandom));
        test_random_traffic(200, 24'd300000);
        idling_on = 1'b0;
        test_random_traffic(200, 24'd40000);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- memory_region_guard_core.f -----
rtl/mrg_pkg.sv
rtl/mrg_region_ram.sv
rtl/mrg_match_unit.sv
rtl/memory_region_guard_core.sv
bench/memory_region_guard_core_test.sv
